// ===== rtl/core/shamh_pkg.sv =====
`default_nettype none
package shamh_pkg;

  typedef logic [7:0][31:0] hash_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COMP,
    ST_FOLD,
    ST_PAD,
    ST_FILL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_PAD,
    MODE_LAST
  } mode_t;

  typedef struct packed {
    logic        byte_we;
    logic [5:0]  byte_idx;
    logic [7:0]  byte_data;
    logic        len_we;
    logic [63:0] len;
    logic        shift;
  } sched_ctrl_t;

  typedef struct packed {
    logic        init;
    logic        load;
    logic        step;
    logic        fold;
    logic [31:0] k;
  } round_ctrl_t;

  localparam hash_t HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/shamh_sched.sv =====
`default_nettype none
module shamh_sched (
  input  wire logic                   clk,
  input  wire shamh_pkg::sched_ctrl_t ctrl,
  output logic [31:0]                 w
);
  import shamh_pkg::*;

  logic [15:0][31:0] win;
  logic [31:0]       sig0;
  logic [31:0]       sig1;
  logic [31:0]       w_next;
  logic [4:0]        lane_pos;

  always_comb begin
    sig0 = {win[1][6:0], win[1][31:7]} ^ {win[1][17:0], win[1][31:18]}
         ^ (win[1] >> 3);
    sig1 = {win[14][16:0], win[14][31:17]} ^ {win[14][18:0], win[14][31:19]}
         ^ (win[14] >> 10);
    w_next = sig1 + win[9] + sig0 + win[0];
    // byte 0 of a word is its most significant byte
    lane_pos = {~ctrl.byte_idx[1:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_next;
    end else if (ctrl.byte_we) begin
      win[ctrl.byte_idx[5:2]][lane_pos +: 8] <= ctrl.byte_data;
    end else if (ctrl.len_we) begin
      win[14] <= ctrl.len[63:32];
      win[15] <= ctrl.len[31:0];
    end
  end

  assign w = win[0];

endmodule
`default_nettype wire

// ===== rtl/core/shamh_round.sv =====
`default_nettype none
module shamh_round (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire shamh_pkg::round_ctrl_t ctrl,
  input  wire logic [31:0]            w,
  output shamh_pkg::hash_t            cv
);
  import shamh_pkg::*;

  hash_t       v;
  hash_t       v_next;
  logic [31:0] up0;
  logic [31:0] up1;
  logic [31:0] pick;
  logic [31:0] vote;
  logic [31:0] sum1;
  logic [31:0] sum2;

  always_comb begin
    up1  = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
         ^ {v[4][24:0], v[4][31:25]};
    pick = (v[4] & v[5]) ^ (~v[4] & v[6]);
    up0  = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
         ^ {v[0][21:0], v[0][31:22]};
    vote = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    sum1 = v[7] + up1 + pick + ctrl.k + w;
    sum2 = up0 + vote;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + sum1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = sum1 + sum2;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= cv;
    end else if (ctrl.step) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= HASH_INIT;
    end else if (ctrl.init) begin
      cv <= HASH_INIT;
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= cv[i] + v[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_message_hasher.sv =====
`default_nettype none
// channel  valid      stall      payload
// message  msg_valid  msg_stall  message_byte, byte_valid, final_item
// digest   dig_valid  dig_stall  digest_word, word_index, digest_last
//
// a byte that does not fill the block is taken without a stall
// a filled block adds a load, 64 rounds on the shared round unit, then a fold
// a final item adds padding, one or two blocks, then 8 words
// msg_stall is high after a byte that fills the block or a final item, until the block is idle again
// dig_stall holds the current digest word; reset is synchronous, active high
module sha256_message_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire logic [7:0]  message_byte,
  input  wire logic        byte_valid,
  input  wire logic        final_item,
  output logic             dig_valid,
  input  wire logic        dig_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             digest_last
);
  import shamh_pkg::*;

  state_t      state;
  state_t      state_next;
  mode_t       mode;
  mode_t       mode_next;
  logic [5:0]  cnt;
  logic [5:0]  cnt_next;
  logic [63:0] bit_len;
  logic [63:0] bit_len_next;
  logic        pend;
  logic        pend_next;
  logic [5:0]  rnd;
  logic [5:0]  rnd_next;
  logic [2:0]  widx;
  logic [2:0]  widx_next;
  sched_ctrl_t sctl;
  round_ctrl_t rctl;
  logic [31:0] w;
  hash_t       cv;

  shamh_sched u_sched (
    .clk  (clk),
    .ctrl (sctl),
    .w    (w)
  );

  shamh_round u_round (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rctl),
    .w    (w),
    .cv   (cv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mode    <= MODE_DATA;
      cnt     <= '0;
      bit_len <= '0;
      pend    <= 1'b0;
      rnd     <= '0;
      widx    <= '0;
    end else begin
      state   <= state_next;
      mode    <= mode_next;
      cnt     <= cnt_next;
      bit_len <= bit_len_next;
      pend    <= pend_next;
      rnd     <= rnd_next;
      widx    <= widx_next;
    end
  end

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    cnt_next       = cnt;
    bit_len_next   = bit_len;
    pend_next      = pend;
    rnd_next       = rnd;
    widx_next      = widx;
    sctl           = '0;
    sctl.byte_idx  = cnt;
    sctl.byte_data = message_byte;
    sctl.len       = bit_len;
    rctl           = '0;
    rctl.k         = round_k(rnd);
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          if (byte_valid) begin
            sctl.byte_we = 1'b1;
            cnt_next     = cnt + 6'd1;
            bit_len_next = bit_len + 64'd8;
            if (cnt == LAST_POS) begin
              state_next = ST_LOAD;
              mode_next  = MODE_DATA;
              pend_next  = final_item;
            end else if (final_item) begin
              state_next = ST_PAD;
            end
          end else if (final_item) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        rctl.load  = 1'b1;
        rnd_next   = '0;
        state_next = ST_COMP;
      end
      ST_COMP: begin
        rctl.step  = 1'b1;
        sctl.shift = 1'b1;
        rnd_next   = rnd + 6'd1;
        if (rnd == LAST_POS) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        rctl.fold = 1'b1;
        unique case (mode)
          MODE_DATA: state_next = pend ? ST_PAD : ST_IDLE;
          MODE_PAD:  state_next = ST_FILL;
          MODE_LAST: state_next = ST_OUT;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        sctl.byte_we   = 1'b1;
        sctl.byte_data = PAD_BYTE;
        cnt_next       = cnt + 6'd1;
        if (cnt == LAST_POS) begin
          state_next = ST_LOAD;
          mode_next  = MODE_PAD;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt == LEN_POS) begin
          sctl.len_we = 1'b1;
          state_next  = ST_LOAD;
          mode_next   = MODE_LAST;
        end else begin
          sctl.byte_we   = 1'b1;
          sctl.byte_data = '0;
          cnt_next       = cnt + 6'd1;
          if (cnt == LAST_POS) begin
            state_next = ST_LOAD;
            mode_next  = MODE_PAD;
          end
        end
      end
      ST_OUT: begin
        if (!dig_stall) begin
          widx_next = widx + 3'd1;
          if (widx == 3'd7) begin
            rctl.init    = 1'b1;
            cnt_next     = '0;
            bit_len_next = '0;
            pend_next    = 1'b0;
            state_next   = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign msg_stall   = (state != ST_IDLE);
  assign dig_valid   = (state == ST_OUT);
  assign digest_word = cv[widx];
  assign word_index  = widx;
  assign digest_last = (widx == 3'd7);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_valid && !msg_stall && dig_valid))
    else $error("message word accepted while digest pending");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && digest_last) |=>
      (cnt == 6'd0 && bit_len == 64'd0 && cv == HASH_INIT))
    else $error("hasher not restarted after digest");

  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && !digest_last) |=>
      (dig_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest words out of sequence");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP && rnd == LAST_POS) |=> (state == ST_FOLD))
    else $error("compression did not end after last round");

endmodule
`default_nettype wire
